>>> rtl/hcmm_pkg.sv
// Shared types, constants and helper functions for the handheld console memory map.
// Used by hcmm_ram, hcmm_ctrl and handheld_console_memory_map; depends on nothing.
package hcmm_pkg;

    localparam int AddrW = 16;
    localparam int ByteW = 8;
    localparam int InDataW = 24;   // address, write_data
    localparam int OutDataW = 16;  // read_data, serial_byte

    localparam logic [AddrW-1:0] RomEnd      = 16'h8000;
    localparam logic [AddrW-1:0] WramLo      = 16'hC000;
    localparam logic [AddrW-1:0] WramHi      = 16'hDFFF;
    localparam logic [AddrW-1:0] EchoLo      = 16'hE000;
    localparam logic [AddrW-1:0] OamBase     = 16'hFE00;
    localparam logic [AddrW-1:0] WramMirLim  = 16'hDE00;
    localparam logic [AddrW-1:0] UnusableLo  = 16'hFEA0;
    localparam logic [AddrW-1:0] UnusableHi  = 16'hFEFF;
    localparam logic [AddrW-1:0] JoypadAddr  = 16'hFF00;
    localparam logic [AddrW-1:0] SerDataAddr = 16'hFF01;
    localparam logic [AddrW-1:0] SerCtlAddr  = 16'hFF02;
    localparam logic [AddrW-1:0] DivAddr     = 16'hFF04;
    localparam logic [AddrW-1:0] IfAddr      = 16'hFF0F;
    localparam logic [AddrW-1:0] LyAddr      = 16'hFF44;
    localparam logic [AddrW-1:0] DmaAddr     = 16'hFF46;
    localparam logic [AddrW-1:0] MirrorUp    = 16'h2000;
    localparam logic [AddrW-1:0] MirrorDown  = 16'hE000;  // minus 0x2000 modulo 2^16

    localparam logic [ByteW-1:0] JoypadVal   = 8'h1F;
    localparam logic [ByteW-1:0] IfSetBits   = 8'hE0;
    localparam logic [ByteW-1:0] SerStartVal = 8'h81;
    localparam logic [ByteW-1:0] OamPage     = 8'hFE;
    localparam logic [ByteW-1:0] DmaLastIdx  = 8'h9F;  // 160 bytes per copy
    localparam logic [AddrW-1:0] LastAddr    = 16'hFFFF;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_MIRROR,
        S_DMA_RD,
        S_DMA_WR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_STORE,
        WR_MIRROR,
        WR_ZERO,
        WR_SERIAL,
        WR_DMA
    } t_wr_kind;

    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [ByteW-1:0] wdata;
        logic [AddrW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [ByteW-1:0] read_data;
        logic             serial_valid;
        logic [ByteW-1:0] serial_byte;
    } t_result;

    // Power-up contents of the map: zero except for the I/O register defaults.
    function automatic logic [ByteW-1:0] default_byte(input logic [AddrW-1:0] addr);
        logic [ByteW-1:0] val;
        begin
            case (addr)
                16'hFF00: val = 8'h1F;
                16'hFF10: val = 8'h80;
                16'hFF11: val = 8'hBF;
                16'hFF12: val = 8'hF3;
                16'hFF14: val = 8'hBF;
                16'hFF16: val = 8'h3F;
                16'hFF19: val = 8'hBF;
                16'hFF1A: val = 8'h7F;
                16'hFF1B: val = 8'hFF;
                16'hFF1C: val = 8'h9F;
                16'hFF1E: val = 8'hBF;
                16'hFF20: val = 8'hFF;
                16'hFF23: val = 8'hBF;
                16'hFF24: val = 8'h77;
                16'hFF25: val = 8'hF3;
                16'hFF26: val = 8'hF1;
                16'hFF40: val = 8'h91;
                16'hFF47: val = 8'hFC;
                16'hFF48: val = 8'hFF;
                16'hFF49: val = 8'hFF;
                default:  val = '0;
            endcase
            return val;
        end
    endfunction

    // Applies the read rules of the two mapped registers to a stored byte.
    function automatic logic [ByteW-1:0] map_read(input logic [AddrW-1:0] addr,
                                                  input logic [ByteW-1:0] stored);
        logic [ByteW-1:0] val;
        begin
            if (addr == JoypadAddr) begin
                val = JoypadVal;
            end else if (addr == IfAddr) begin
                val = stored | IfSetBits;
            end else begin
                val = stored;
            end
            return val;
        end
    endfunction

endpackage

>>> rtl/handheld_console_memory_map.sv
// Handheld console memory map: one byte read or write per input word against a 64 KiB
// byte store, with region write rules, work/echo RAM mirroring, a serial byte output and
// a 160-byte OAM copy. After reset the block runs an initialization sweep over the store
// (one store entry per cycle, loading zero or the I/O power-up default) and is not ready
// until it ends. Afterwards a new word is accepted only once the previous access is
// through; a mirrored RAM write makes a second store write, and a write to the DMA
// register reads and then writes each of the copied bytes in turn. A finished result sits
// in an output register, so the next word is taken while it waits. Depends on hcmm_pkg,
// hcmm_ram and hcmm_ctrl.
module handheld_console_memory_map
    import hcmm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [InDataW-1:0]  i_s_tdata,   // address[15:0], write_data[23:16]
    input  logic                i_s_tuser,   // operation[0]: 0 read, 1 write
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OutDataW-1:0] o_m_tdata,   // read_data[7:0], serial_byte[15:8]
    output logic                o_m_tuser    // serial_valid[0]
);

    t_mem_req         mem_req;
    logic [ByteW-1:0] mem_rdata;
    logic             fin;
    t_result          res;
    logic             slot_free;

    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic                r_out_user;

    assign slot_free = !r_out_valid || i_m_tready;

    hcmm_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    hcmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_op        (i_s_tuser),
        .i_addr      (i_s_tdata[AddrW-1:0]),
        .i_wdata     (i_s_tdata[AddrW+ByteW-1:AddrW]),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_fin       (fin),
        .o_res       (res),
        .i_slot_free (slot_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin && slot_free) begin
            r_out_data <= {res.serial_byte, res.read_data};
            r_out_user <= res.serial_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

>>> rtl/hcmm_ram.sv
// 64 KiB byte store with one write port and one registered read port.
// Depends on hcmm_pkg for widths and the request struct.
module hcmm_ram
    import hcmm_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_req         i_req,
    output logic [ByteW-1:0] o_rdata
);

    logic [ByteW-1:0] r_mem [0:(1<<AddrW)-1];
    logic [ByteW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hcmm_ctrl.sv
// Access sequencer: initialization sweep, write decode, mirror writes and the OAM copy,
// all address arithmetic through one shared adder. Depends on hcmm_pkg.
module hcmm_ctrl
    import hcmm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_op,
    input  logic [AddrW-1:0] i_addr,
    input  logic [ByteW-1:0] i_wdata,
    output t_mem_req         o_mem,
    input  logic [ByteW-1:0] i_mem_rdata,
    output logic             o_fin,
    output t_result          o_res,
    input  logic             i_slot_free
);

    t_state           r_state, n_state;
    logic [AddrW-1:0] r_addr, n_addr;
    logic [ByteW-1:0] r_wdata, n_wdata;
    logic [AddrW-1:0] r_maddr, n_maddr;
    logic [ByteW-1:0] r_cnt, n_cnt;
    logic [AddrW-1:0] r_clr, n_clr;
    t_result          r_res, n_res;

    t_wr_kind         wr_kind;
    logic [AddrW-1:0] add_a, add_b, add_sum;
    logic [AddrW-1:0] dma_src;
    logic             dma_last;

    assign dma_src  = {r_wdata, r_cnt};
    assign dma_last = (r_cnt == DmaLastIdx);

    // Write decode, first matching region wins.
    always_comb begin
        if (r_addr < RomEnd) begin
            wr_kind = WR_NONE;
        end else if (r_addr >= WramLo && r_addr <= WramHi) begin
            wr_kind = (r_addr < WramMirLim) ? WR_MIRROR : WR_STORE;
        end else if (r_addr >= EchoLo && r_addr < OamBase) begin
            wr_kind = WR_MIRROR;
        end else if (r_addr >= UnusableLo && r_addr <= UnusableHi) begin
            wr_kind = WR_NONE;
        end else if (r_addr == SerDataAddr) begin
            wr_kind = WR_SERIAL;
        end else if (r_addr == SerCtlAddr && r_wdata == SerStartVal) begin
            wr_kind = WR_NONE;
        end else if (r_addr == DivAddr || r_addr == LyAddr) begin
            wr_kind = WR_ZERO;
        end else if (r_addr == DmaAddr) begin
            wr_kind = WR_DMA;
        end else begin
            wr_kind = WR_STORE;
        end
    end

    // Shared adder: sweep address during the initialization sweep, mirror address in
    // the write step, copy index in the copy loop.
    always_comb begin
        if (r_state == S_CLEAR) begin
            add_a = r_clr;
            add_b = {{(AddrW-1){1'b0}}, 1'b1};
        end else if (r_state == S_DMA_WR) begin
            add_a = {{(AddrW-ByteW){1'b0}}, r_cnt};
            add_b = {{(AddrW-1){1'b0}}, 1'b1};
        end else begin
            add_a = r_addr;
            add_b = r_addr[13] ? MirrorDown : MirrorUp;
        end
        add_sum = add_a + add_b;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LastAddr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_op ? S_WRITE : S_READ;
            end
            S_READ: begin
                n_state = i_slot_free ? S_IDLE : S_DONE;
            end
            S_WRITE: begin
                case (wr_kind)
                    WR_MIRROR: n_state = S_MIRROR;
                    WR_DMA:    n_state = S_DMA_RD;
                    default:   n_state = i_slot_free ? S_IDLE : S_DONE;
                endcase
            end
            S_MIRROR: begin
                n_state = i_slot_free ? S_IDLE : S_DONE;
            end
            S_DMA_RD: begin
                n_state = S_DMA_WR;
            end
            S_DMA_WR: begin
                if (dma_last) begin
                    n_state = i_slot_free ? S_IDLE : S_DONE;
                end else begin
                    n_state = S_DMA_RD;
                end
            end
            S_DONE: begin
                if (i_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Memory requests and results.
    always_comb begin
        o_mem       = '0;
        o_mem.raddr = i_addr;
        o_fin       = 1'b0;
        o_res       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr;
                o_mem.wdata = default_byte(r_clr);
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_READ: begin
                o_fin           = 1'b1;
                o_res.read_data = map_read(r_addr, i_mem_rdata);
            end
            S_WRITE: begin
                case (wr_kind)
                    WR_STORE: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_addr;
                        o_mem.wdata = r_wdata;
                        o_fin       = 1'b1;
                    end
                    WR_MIRROR: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_addr;
                        o_mem.wdata = r_wdata;
                    end
                    WR_ZERO: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_addr;
                        o_fin       = 1'b1;
                    end
                    WR_SERIAL: begin
                        o_fin              = 1'b1;
                        o_res.serial_valid = 1'b1;
                        o_res.serial_byte  = r_wdata;
                    end
                    WR_DMA: begin
                        o_fin = 1'b0;
                    end
                    default: begin
                        o_fin = 1'b1;
                    end
                endcase
            end
            S_MIRROR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_maddr;
                o_mem.wdata = r_wdata;
                o_fin       = 1'b1;
            end
            S_DMA_RD: begin
                o_mem.raddr = dma_src;
            end
            S_DMA_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = {OamPage, r_cnt};
                o_mem.wdata = map_read(dma_src, i_mem_rdata);
                o_fin       = dma_last;
            end
            S_DONE: begin
                o_fin = 1'b1;
                o_res = r_res;
            end
            default: begin
                o_fin = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb begin
        n_addr  = r_addr;
        n_wdata = r_wdata;
        n_maddr = r_maddr;
        n_cnt   = r_cnt;
        n_clr   = r_clr;
        n_res   = r_res;
        if (r_state == S_CLEAR) begin
            n_clr = add_sum;
        end
        if (r_state == S_IDLE && i_in_valid) begin
            n_addr  = i_addr;
            n_wdata = i_wdata;
        end
        if (r_state == S_WRITE) begin
            n_maddr = add_sum;
            n_cnt   = '0;
        end
        if (r_state == S_DMA_WR) begin
            n_cnt = add_sum[ByteW-1:0];
        end
        // A finished word that cannot leave yet is parked until the output frees up.
        if (o_fin && !i_slot_free) begin
            n_res = o_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_wdata <= n_wdata;
        r_maddr <= n_maddr;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
    end

endmodule

>>> bench/handheld_console_memory_map_tb.sv
// Self-checking bench for handheld_console_memory_map: a directed table of accesses, then
// random reads and writes across every region, scored against a byte-image predictor.
// Depends on hcmm_pkg and the handheld_console_memory_map RTL.
module handheld_console_memory_map_tb;
    import hcmm_pkg::*;

    localparam logic OpRead  = 1'b0;
    localparam logic OpWrite = 1'b1;
    localparam logic Typed   = 1'b1;
    localparam logic Pred    = 1'b0;

    localparam int NumRandom = 1420;
    localparam int CalmFrom  = 600;
    localparam int CalmTo    = 800;
    localparam int HoldAt    = 330;
    localparam int HoldLen   = 400;

    localparam int NumPowerUp = 20;
    localparam logic [AddrW-1:0] PowerUpAddr [NumPowerUp] = '{
        16'hFF00, 16'hFF10, 16'hFF11, 16'hFF12, 16'hFF14, 16'hFF16, 16'hFF19,
        16'hFF1A, 16'hFF1B, 16'hFF1C, 16'hFF1E, 16'hFF20, 16'hFF23, 16'hFF24,
        16'hFF25, 16'hFF26, 16'hFF40, 16'hFF47, 16'hFF48, 16'hFF49};
    localparam logic [ByteW-1:0] PowerUpVal [NumPowerUp] = '{
        8'h1F, 8'h80, 8'hBF, 8'hF3, 8'hBF, 8'h3F, 8'hBF,
        8'h7F, 8'hFF, 8'h9F, 8'hBF, 8'hFF, 8'hBF, 8'h77,
        8'hF3, 8'hF1, 8'h91, 8'hFC, 8'hFF, 8'hFF};

    localparam int NumIoRegs = 8;
    localparam logic [AddrW-1:0] IoRegs [NumIoRegs] = '{
        JoypadAddr, SerDataAddr, SerCtlAddr, DivAddr, IfAddr, LyAddr, DmaAddr, LastAddr};

    typedef struct packed {
        logic             op;
        logic [AddrW-1:0] addr;
        logic [ByteW-1:0] data;
        logic             typed;
        logic [ByteW-1:0] rd;
        logic             sv;
        logic [ByteW-1:0] sb;
    } t_probe_row;

    localparam int NumProbe = 28;
    localparam t_probe_row ProbeRows [NumProbe] = '{
        '{OpRead,  16'h0000,    8'h00, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  JoypadAddr,  8'hFF, Typed, 8'h1F, 1'b0, 8'h00},
        '{OpRead,  IfAddr,      8'h00, Typed, 8'hE0, 1'b0, 8'h00},
        '{OpRead,  16'hFF40,    8'h00, Typed, 8'h91, 1'b0, 8'h00},
        '{OpWrite, 16'h7FFF,    8'hFF, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  16'h7FFF,    8'h00, Typed, 8'h00, 1'b0, 8'h00},
        '{OpWrite, WramLo,      8'h5A, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  EchoLo,      8'h00, Pred,  8'h00, 1'b0, 8'h00},
        '{OpWrite, WramMirLim,  8'h33, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  OamBase,     8'h00, Typed, 8'h00, 1'b0, 8'h00},
        '{OpWrite, 16'hFDFF,    8'hA5, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  16'hDDFF,    8'h00, Pred,  8'h00, 1'b0, 8'h00},
        '{OpWrite, UnusableLo,  8'h77, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  UnusableLo,  8'h00, Typed, 8'h00, 1'b0, 8'h00},
        '{OpWrite, SerDataAddr, 8'hC3, Typed, 8'h00, 1'b1, 8'hC3},
        '{OpWrite, SerCtlAddr,  8'h81, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  SerCtlAddr,  8'h00, Typed, 8'h00, 1'b0, 8'h00},
        '{OpWrite, DivAddr,     8'hFF, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  DivAddr,     8'h00, Typed, 8'h00, 1'b0, 8'h00},
        '{OpWrite, LyAddr,      8'hFF, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  LyAddr,      8'h00, Typed, 8'h00, 1'b0, 8'h00},
        '{OpWrite, IfAddr,      8'h01, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  IfAddr,      8'h00, Pred,  8'h00, 1'b0, 8'h00},
        '{OpWrite, DmaAddr,     8'hC0, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  OamBase,     8'h00, Pred,  8'h00, 1'b0, 8'h00},
        '{OpWrite, DmaAddr,     8'hFF, Typed, 8'h00, 1'b0, 8'h00},
        '{OpRead,  16'hFE0F,    8'h00, Pred,  8'h00, 1'b0, 8'h00},
        '{OpRead,  LastAddr,    8'h00, Typed, 8'h00, 1'b0, 8'h00}};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [InDataW-1:0]  i_s_tdata;   // address[15:0], write_data[23:16]
    logic                i_s_tuser;   // operation[0]
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OutDataW-1:0] o_m_tdata;   // read_data[7:0], serial_byte[15:8]
    logic                o_m_tuser;   // serial_valid[0]

    logic [ByteW-1:0] map_image [65536];
    t_result          pending_results [$];
    logic [AddrW-1:0] recent_writes [$];

    int  words_in;
    int  results_seen;
    int  mismatches;
    int  oam_copies;
    int  serial_bytes;
    bit  calm;

    handheld_console_memory_map uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic void load_power_up_image();
        for (int a = 0; a < 65536; a++) begin
            map_image[a] = '0;
        end
        for (int k = 0; k < NumPowerUp; k++) begin
            map_image[PowerUpAddr[k]] = PowerUpVal[k];
        end
    endfunction

    function automatic logic [ByteW-1:0] mapped_byte(input logic [AddrW-1:0] addr);
        logic [ByteW-1:0] val;
        val = map_image[addr];
        if (addr == JoypadAddr) begin
            val = JoypadVal;
        end else if (addr == IfAddr) begin
            val = val | IfSetBits;
        end
        return val;
    endfunction

    // Applies one access to the image and returns the word the block should produce.
    function automatic t_result apply_access(input logic op, input logic [AddrW-1:0] addr,
                                             input logic [ByteW-1:0] data);
        t_result          res;
        logic [AddrW-1:0] src;
        res = '0;
        if (op == OpRead) begin
            res.read_data = mapped_byte(addr);
        end else if (addr < RomEnd) begin
            res = '0;
        end else if (addr >= WramLo && addr <= WramHi) begin
            map_image[addr] = data;
            // The upper end of work RAM would mirror into OAM and I/O, so it is dropped.
            if (addr < WramMirLim) begin
                map_image[addr + MirrorUp] = data;
            end
        end else if (addr >= EchoLo && addr < OamBase) begin
            map_image[addr] = data;
            map_image[addr - MirrorUp] = data;
        end else if (addr >= UnusableLo && addr <= UnusableHi) begin
            res = '0;
        end else if (addr == SerDataAddr) begin
            res.serial_valid = 1'b1;
            res.serial_byte  = data;
        end else if (addr == SerCtlAddr && data == SerStartVal) begin
            res = '0;
        end else if (addr == DivAddr || addr == LyAddr) begin
            map_image[addr] = '0;
        end else if (addr == DmaAddr) begin
            // Byte by byte in ascending order, so a source page overlapping OAM sees
            // the bytes already copied.
            for (int i = 0; i <= int'(DmaLastIdx); i++) begin
                src = {data, 8'h00} + AddrW'(i);
                map_image[OamBase + AddrW'(i)] = mapped_byte(src);
            end
        end else begin
            map_image[addr] = data;
        end
        return res;
    endfunction

    task automatic offer_word(input logic op, input logic [AddrW-1:0] addr,
                              input logic [ByteW-1:0] data, input logic use_typed,
                              input t_result typed_res);
        t_result res;
        if (!calm) begin
            while ($urandom_range(99) < 35) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {data, addr};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        res = apply_access(op, addr, data);
        pending_results.push_back(use_typed ? typed_res : res);
        words_in++;
        if (op == OpWrite && addr == DmaAddr) begin
            oam_copies++;
        end
        if (op == OpWrite && addr >= RomEnd) begin
            recent_writes.push_back(addr);
            if (recent_writes.size() > 32) begin
                void'(recent_writes.pop_front());
            end
        end
    endtask

    // Output side: random back-pressure, one long hold-off, and a calm stretch.
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && words_in >= HoldAt) begin
                hold_done = 1;
                hold_left = HoldLen;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= calm || ($urandom_range(99) >= 35);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.read_data    = o_m_tdata[7:0];
            got.serial_byte  = o_m_tdata[15:8];
            got.serial_valid = o_m_tuser;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, actual rd=%h sv=%b sb=%h", $time,
                         got.read_data, got.serial_valid, got.serial_byte);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, got.read_data);
                    mismatches++;
                end
                if (got.serial_valid !== want.serial_valid) begin
                    $display("%0t: serial_valid expected %b actual %b", $time,
                             want.serial_valid, got.serial_valid);
                    mismatches++;
                end
                if (got.serial_byte !== want.serial_byte) begin
                    $display("%0t: serial_byte expected %h actual %h", $time,
                             want.serial_byte, got.serial_byte);
                    mismatches++;
                end
                if (want.serial_valid) begin
                    serial_bytes++;
                end
            end
        end
    end

    initial begin : stimulus
        t_result          typed_res;
        logic             op;
        logic [AddrW-1:0] addr;
        logic [ByteW-1:0] data;
        int               pick;
        words_in     = 0;
        results_seen = 0;
        mismatches   = 0;
        oam_copies   = 0;
        serial_bytes = 0;
        calm         = 0;
        load_power_up_image();
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= OpRead;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NumProbe; r++) begin
            typed_res.read_data    = ProbeRows[r].rd;
            typed_res.serial_valid = ProbeRows[r].sv;
            typed_res.serial_byte  = ProbeRows[r].sb;
            offer_word(ProbeRows[r].op, ProbeRows[r].addr, ProbeRows[r].data,
                       ProbeRows[r].typed, typed_res);
        end

        typed_res = '0;
        for (int n = 0; n < NumRandom; n++) begin
            calm = (n >= CalmFrom && n < CalmTo);
            op   = $urandom_range(1) ? OpWrite : OpRead;
            data = ByteW'($urandom_range(255));
            pick = $urandom_range(99);
            if (op == OpRead && recent_writes.size() > 0 && pick < 50) begin
                // Read back something written lately, often through its mirror.
                addr = recent_writes[$urandom_range(recent_writes.size() - 1)];
                if ($urandom_range(1)) begin
                    if (addr >= WramLo && addr < WramMirLim) begin
                        addr = addr + MirrorUp;
                    end else if (addr >= EchoLo && addr < OamBase) begin
                        addr = addr - MirrorUp;
                    end
                end
            end else begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    addr = AddrW'($urandom_range(16'h7FFF));
                end else if (pick < 18) begin
                    addr = AddrW'($urandom_range(16'hBFFF, 16'h8000));
                end else if (pick < 30) begin
                    addr = AddrW'($urandom_range(16'hDFFF, 16'hC000));
                end else if (pick < 36) begin
                    addr = AddrW'($urandom_range(16'hDFFF, 16'hDDF0));
                end else if (pick < 48) begin
                    addr = AddrW'($urandom_range(16'hFDFF, 16'hE000));
                end else if (pick < 58) begin
                    addr = AddrW'($urandom_range(16'hFE9F, 16'hFE00));
                end else if (pick < 63) begin
                    addr = AddrW'($urandom_range(16'hFEFF, 16'hFEA0));
                end else if (pick < 78) begin
                    addr = IoRegs[$urandom_range(NumIoRegs - 1)];
                end else if (pick < 90) begin
                    addr = AddrW'($urandom_range(16'hFFFF, 16'hFF00));
                end else begin
                    addr = AddrW'($urandom_range(16'hFFFF));
                end
            end
            if (op == OpWrite && addr == SerCtlAddr && $urandom_range(1)) begin
                data = SerStartVal;
            end
            if (op == OpWrite && addr == DmaAddr && $urandom_range(1)) begin
                data = ByteW'($urandom_range(8'hFF, 8'hC0));
            end
            offer_word(op, addr, data, Pred, typed_res);
        end
        calm = 0;
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        $display("Covered %0d words (%0d results checked), %0d OAM copies, %0d serial bytes,",
                 words_in, results_seen, oam_copies, serial_bytes);
        $display("with random stalls on both sides, a calm stretch and one long output hold.");
        if (mismatches == 0) begin
            $display("handheld_console_memory_map_tb: done, clean");
        end else begin
            $display("handheld_console_memory_map_tb: done, errors");
        end
        $finish;
    end

    // The block initializes its whole store after reset before it takes words; the limit allows for it.
    initial begin : watchdog
        #10000000;
        $display("handheld_console_memory_map_tb: done, errors");
        $finish;
    end

endmodule
